// ===== src/cenc_pkg.sv =====
// Shared types, constants and the tap function of the convolutional encoder.
package cenc_pkg;

  localparam int REG_W      = 7;
  localparam int GEN_W      = 8;
  localparam int NGEN       = 4;
  localparam int CODE_W     = 4;
  localparam int MLEN_W     = 3;
  localparam int OCNT_W     = 3;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [MODE_W-1:0] MODE_NSC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RSC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PRE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_LEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL_EN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GEN       = 3'd5;

  typedef struct packed {
    logic [MODE_W-1:0]      md;
    logic [MLEN_W-1:0]      m;
    logic [CODE_W-1:0]      code_mask;
    logic                   tail;
    logic                   u;
    logic [REG_W-1:0]       sr;
    logic [NGEN*GEN_W-1:0]  gens;
  } step_req_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [REG_W-1:0]  sr_next;
    logic              tail_input;
  } step_res_t;

  // Bit m of the generator taps the first bit; bit m-1-j taps register bit j.
  function automatic logic tap_xor(input logic [GEN_W-1:0] g, input logic first,
                                   input logic [REG_W-1:0] sr, input logic [MLEN_W-1:0] m);
    logic              v;
    logic [MLEN_W-1:0] t;
    v = g[m] & first;
    for (int j = 0; j < REG_W; j++) begin
      t = m - MLEN_W'(j) - 1'b1;
      if (MLEN_W'(j) < m) begin
        v = v ^ (g[t] & sr[j]);
      end
    end
    return v;
  endfunction

endpackage

// ===== src/cenc_step.sv =====
// One encoder step: code bits and next register for a data or termination step.
module cenc_step (
  input  cenc_pkg::step_req_t req_i,
  output cenc_pkg::step_res_t res_o
);

  logic [cenc_pkg::GEN_W-1:0]  g0;
  logic                        fb;
  logic                        tail0;
  logic                        par_first;
  logic                        shin;
  logic [cenc_pkg::CODE_W-1:0] par;
  logic [cenc_pkg::CODE_W-1:0] code;
  logic [cenc_pkg::REG_W-1:0]  mask;

  always_comb begin
    g0    = req_i.gens[cenc_pkg::GEN_W-1:0];
    fb    = cenc_pkg::tap_xor(g0, req_i.u, req_i.sr, req_i.m);
    tail0 = cenc_pkg::tap_xor(g0, 1'b0, req_i.sr, req_i.m);
    mask  = ~({cenc_pkg::REG_W{1'b1}} << req_i.m);
    if (req_i.tail) begin
      par_first = 1'b0;
    end else if (req_i.md == cenc_pkg::MODE_RSC) begin
      par_first = fb;
    end else begin
      par_first = req_i.u;
    end
    for (int k = 0; k < cenc_pkg::NGEN; k++) begin
      par[k] = cenc_pkg::tap_xor(req_i.gens[k*cenc_pkg::GEN_W +: cenc_pkg::GEN_W],
                                 par_first, req_i.sr, req_i.m);
    end
    res_o.tail_input = 1'b0;
    if (req_i.tail) begin
      code = par;
      shin = 1'b0;
      if (req_i.md == cenc_pkg::MODE_RSC) begin
        res_o.tail_input = tail0;
      end
    end else begin
      unique case (req_i.md)
        cenc_pkg::MODE_RSC: begin
          code = {par[cenc_pkg::CODE_W-1:1], req_i.u};
          shin = fb;
        end
        cenc_pkg::MODE_PRE: begin
          code = {{(cenc_pkg::CODE_W-1){1'b0}}, fb};
          shin = fb;
        end
        default: begin
          code = par;
          shin = req_i.u;
        end
      endcase
    end
    res_o.code    = code & req_i.code_mask;
    res_o.sr_next = {req_i.sr[cenc_pkg::REG_W-2:0], shin} & mask;
  end

endmodule

// ===== src/convolutional_encoder_core.sv =====
// Top level of the convolutional encoder: configuration, control and result register.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o   | in_data_bit_i, in_block_end_i
//   out     | output    | out_valid_o / out_stall_i | out_code_bits_o, out_tail_step_o,
//           |           |                           | out_tail_input_o, out_last_o
//   cfg     | input     | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// A data beat is encoded into the result register, one beat per cycle while the output is not stalled.
// A last beat with termination adds memory_length result beats, one per cycle while not stalled,
// during which no input beat is taken.
// Reset loads the register defaults, clears the shift register and marks a block start.
// A stalled result holds the result register and stalls the input side in turn.
module convolutional_encoder_core #(
  parameter int MAX_OUTPUTS = 4,
  parameter int MAX_MEMORY  = 7
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cenc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [cenc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                in_data_bit_i,
  input  logic                                in_block_end_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [cenc_pkg::CODE_W-1:0]         out_code_bits_o,
  output logic                                out_tail_step_o,
  output logic                                out_tail_input_o,
  output logic                                out_last_o
);

  localparam int SR_W = (MAX_MEMORY < cenc_pkg::REG_W) ? MAX_MEMORY : cenc_pkg::REG_W;
  localparam logic [3:0] MAX_OUT_V = 4'(MAX_OUTPUTS);
  localparam logic [3:0] MAX_MEM_V = 4'(MAX_MEMORY);

  logic [cenc_pkg::MODE_W-1:0]     mode_q;
  logic [cenc_pkg::OCNT_W-1:0]     ocnt_q;
  logic [cenc_pkg::MLEN_W-1:0]     mlen_q;
  logic [cenc_pkg::REG_W-1:0]      init_q;
  logic                            tail_en_q;
  logic [cenc_pkg::CFG_DATA_W-1:0] gen_q;

  logic [SR_W-1:0]                 sr_q, sr_d;
  logic                            blk_start_q, blk_start_d;
  logic [cenc_pkg::MLEN_W-1:0]     tail_left_q, tail_left_d;
  logic                            out_valid_q, out_valid_d;
  logic [cenc_pkg::CODE_W-1:0]     code_q, code_d;
  logic                            tstep_q, tstep_d;
  logic                            tin_q, tin_d;
  logic                            last_q, last_d;

  logic [cenc_pkg::MODE_W-1:0]     md;
  logic [cenc_pkg::MLEN_W-1:0]     m_eff;
  logic [3:0]                      nout;
  logic                            load;
  logic                            in_acc;
  logic                            tail_go;
  logic                            tail_start;
  cenc_pkg::step_req_t             req;
  cenc_pkg::step_res_t             res;

  always_comb begin
    md = (mode_q == cenc_pkg::MODE_PRE || mode_q == cenc_pkg::MODE_RSC) ? mode_q
                                                                          : cenc_pkg::MODE_NSC;
    if (mlen_q == '0) begin
      m_eff = cenc_pkg::MLEN_W'(1);
    end else if ({1'b0, mlen_q} > MAX_MEM_V) begin
      m_eff = MAX_MEM_V[cenc_pkg::MLEN_W-1:0];
    end else begin
      m_eff = mlen_q;
    end
    if (ocnt_q == '0) begin
      nout = 4'd1;
    end else if ({1'b0, ocnt_q} > MAX_OUT_V) begin
      nout = MAX_OUT_V;
    end else begin
      nout = {1'b0, ocnt_q};
    end
  end

  assign load       = !out_valid_q || !out_stall_i;
  assign in_stall_o = !load || (tail_left_q != '0);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign tail_go    = load && (tail_left_q != '0);
  assign tail_start = in_acc && in_block_end_i && tail_en_q && (md != cenc_pkg::MODE_PRE);

  always_comb begin
    req.md   = md;
    req.m    = m_eff;
    req.tail = tail_go;
    req.u    = in_data_bit_i;
    req.gens = gen_q;
    for (int k = 0; k < cenc_pkg::CODE_W; k++) begin
      req.code_mask[k] = (4'(k) < nout);
    end
    if (!tail_go && blk_start_q) begin
      req.sr = init_q;
    end else begin
      req.sr = cenc_pkg::REG_W'(sr_q);
    end
  end

  cenc_step u_step (
    .req_i (req),
    .res_o (res)
  );

  always_comb begin
    sr_d        = sr_q;
    blk_start_d = blk_start_q;
    tail_left_d = tail_left_q;
    out_valid_d = load ? (in_acc || tail_go) : out_valid_q;
    code_d      = code_q;
    tstep_d     = tstep_q;
    tin_d       = tin_q;
    last_d      = last_q;
    if (tail_go) begin
      sr_d        = res.sr_next[SR_W-1:0];
      tail_left_d = tail_left_q - 1'b1;
      code_d      = res.code;
      tstep_d     = 1'b1;
      tin_d       = res.tail_input;
      last_d      = (tail_left_q == cenc_pkg::MLEN_W'(1));
    end else if (in_acc) begin
      sr_d        = res.sr_next[SR_W-1:0];
      blk_start_d = in_block_end_i;
      tail_left_d = tail_start ? m_eff : '0;
      code_d      = res.code;
      tstep_d     = 1'b0;
      tin_d       = 1'b0;
      last_d      = !tail_start;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_q        <= '0;
      blk_start_q <= 1'b1;
      tail_left_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sr_q        <= sr_d;
      blk_start_q <= blk_start_d;
      tail_left_q <= tail_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q  <= code_d;
    tstep_q <= tstep_d;
    tin_q   <= tin_d;
    last_q  <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= cenc_pkg::MODE_NSC;
      ocnt_q    <= cenc_pkg::OCNT_W'(2);
      mlen_q    <= cenc_pkg::MLEN_W'(2);
      init_q    <= '0;
      tail_en_q <= 1'b0;
      gen_q     <= cenc_pkg::CFG_DATA_W'(1287);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cenc_pkg::CFG_MODE:      mode_q    <= cfg_wdata_i[cenc_pkg::MODE_W-1:0];
        cenc_pkg::CFG_OUT_COUNT: ocnt_q    <= cfg_wdata_i[cenc_pkg::OCNT_W-1:0];
        cenc_pkg::CFG_MEM_LEN:   mlen_q    <= cfg_wdata_i[cenc_pkg::MLEN_W-1:0];
        cenc_pkg::CFG_INIT:      init_q    <= cfg_wdata_i[cenc_pkg::REG_W-1:0];
        cenc_pkg::CFG_TAIL_EN:   tail_en_q <= cfg_wdata_i[0];
        cenc_pkg::CFG_GEN:       gen_q     <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_code_bits_o  = code_q;
  assign out_tail_step_o  = tstep_q;
  assign out_tail_input_o = tin_q;
  assign out_last_o       = last_q;

`ifndef SYNTHESIS
  a_tail_first_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_start |=> out_valid_o && !out_last_o && !out_tail_step_o)
    else $error("Data beat before termination was marked last.");

  a_tail_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_tail_step_o && !out_last_o |-> tail_left_q != '0)
    else $error("Termination beat not last but no steps remain.");

  a_tail_zero_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_tail_step_o && out_last_o |-> sr_q == '0 && tail_left_q == '0)
    else $error("Termination ended with a nonzero shift register.");
`endif

endmodule
